>>> rtl/core/ordered_unique_set_store_unit_defines.svh
// ----------------------------------------------------------------------------
// ordered unique set store - assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef ORDERED_UNIQUE_SET_STORE_UNIT_DEFINES_SVH
`define ORDERED_UNIQUE_SET_STORE_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define OUSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ouss port check failed");

// next-cycle implication, reset masked
`define OUSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ouss port check failed");

`endif

>>> rtl/core/ouss_pkg.sv
// ----------------------------------------------------------------------------
// ouss_pkg
// shared types and codes for the ordered unique set store
// ----------------------------------------------------------------------------
package ouss_pkg;

  localparam int OP_W      = 2;
  localparam int KEY_IN_W  = 32;
  localparam int SLOT_W    = 6;
  localparam int CNT_OUT_W = 7;
  localparam int ST_W      = 2;

  localparam int SET_CAPACITY_DEF = 64;
  localparam int KEY_WIDTH_DEF    = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // one finished result word
  typedef struct packed {
    logic                 found;
    logic [KEY_IN_W-1:0]  read_value;
    logic [CNT_OUT_W-1:0] entry_count;
    status_t              status;
  } res_t;

endpackage

>>> rtl/core/ouss_if.sv
// ----------------------------------------------------------------------------
// ouss channel interfaces
// valid/ready channels for operation words and result words
// ----------------------------------------------------------------------------
interface ouss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] key;
  logic [5:0]  slot;

  modport source (output valid, operation, key, slot, input ready);
  modport sink   (input valid, operation, key, slot, output ready);
endinterface

interface ouss_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] read_value;
  logic [6:0]  entry_count;
  logic [1:0]  status;

  modport source (output valid, found, read_value, entry_count, status, input ready);
  modport sink   (input valid, found, read_value, entry_count, status, output ready);
endinterface

>>> rtl/core/ouss_key_ram.sv
// ----------------------------------------------------------------------------
// ouss_key_ram
// key memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module ouss_key_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/ouss_seq.sv
// ----------------------------------------------------------------------------
// ouss_seq
// sequencer: serial key scan through one comparator, shift-down on remove
// ----------------------------------------------------------------------------
module ouss_seq #(
  parameter int SET_CAPACITY = 64,
  parameter int SW           = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [ouss_pkg::OP_W-1:0]       in_operation,
  input  logic [ouss_pkg::KEY_IN_W-1:0]   in_key,
  input  logic [ouss_pkg::SLOT_W-1:0]     in_slot,
  output logic                            in_rdy,
  input  logic                            out_free,
  output logic                            done,
  output ouss_pkg::res_t                  res,
  output logic                            wr_en,
  output logic [$clog2(SET_CAPACITY)-1:0] wr_addr,
  output logic [SW-1:0]                   wr_data,
  output logic                            rd_en,
  output logic [$clog2(SET_CAPACITY)-1:0] rd_addr,
  input  logic [SW-1:0]                   rd_data
);
  import ouss_pkg::*;

  localparam int IDX_W = $clog2(SET_CAPACITY);
  localparam int CNT_W = $clog2(SET_CAPACITY + 1);
  localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_SHIFT,
    S_RD_WAIT
  } state_t;

  state_t             state_r, state_nxt;
  op_t                op_r;
  logic [SW-1:0]      key_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic               slot_ok;
  logic               full;
  logic [CNT_W-1:0]   idx_p1;
  logic [CNT_W:0]     idx_p2;
  logic               hit;
  logic               lk_done;
  logic               lk_found;

  assign slot_ok = CMP_W'(slot_r) < CMP_W'(count_r);
  assign full    = count_r >= CNT_W'(SET_CAPACITY);
  assign idx_p1  = CNT_W'(idx_r) + CNT_W'(1);
  assign idx_p2  = (CNT_W + 1)'(idx_r) + (CNT_W + 1)'(2);
  assign hit     = rd_data == key_r;
  assign in_rdy  = state_r == S_IDLE;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_addr    = idx_r;
    done       = 1'b0;
    lk_done    = 1'b0;
    lk_found   = 1'b0;
    res.found       = 1'b0;
    res.read_value  = '0;
    res.entry_count = '0;
    res.status      = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (op_r == OP_READ) begin
          if (slot_ok) begin
            rd_en     = 1'b1;
            rd_addr   = IDX_W'(slot_r);
            state_nxt = S_RD_WAIT;
          end else if (out_free) begin
            done       = 1'b1;
            res.status = ST_RANGE;
            state_nxt  = S_IDLE;
          end
        end else if (count_r == '0) begin
          lk_done = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // one stored key compared per cycle
        if (hit) begin
          lk_done  = 1'b1;
          lk_found = 1'b1;
        end else if (idx_p1 >= count_r) begin
          lk_done = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(idx_p1);
          idx_nxt = IDX_W'(idx_p1);
        end
      end
      S_SHIFT: begin
        // move entry idx+1 down into idx
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data;
        if (idx_p2 < (CNT_W + 1)'(count_r)) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(idx_p2);
          idx_nxt = IDX_W'(idx_p1);
        end else if (out_free) begin
          count_nxt = count_r - CNT_W'(1);
          done      = 1'b1;
          res.found = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RD_WAIT: begin
        if (out_free) begin
          done           = 1'b1;
          res.read_value = KEY_IN_W'($signed(rd_data));
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // end of a key lookup: update by operation
    if (lk_done && out_free) begin
      res.found = lk_found;
      state_nxt = S_IDLE;
      done      = 1'b1;
      case (op_r)
        OP_INSERT: begin
          if (!lk_found) begin
            if (full) begin
              res.status = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = IDX_W'(count_r);
              wr_data   = key_r;
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end
        OP_REMOVE: begin
          if (lk_found) begin
            if (idx_p1 < count_r) begin
              rd_en     = 1'b1;
              rd_addr   = IDX_W'(idx_p1);
              done      = 1'b0;
              state_nxt = S_SHIFT;
            end else begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end

    res.entry_count = CNT_OUT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (accept) begin
        op_r   <= op_t'(in_operation);
        key_r  <= in_key[SW-1:0];
        slot_r <= in_slot;
      end
    end
  end

endmodule

>>> rtl/core/ordered_unique_set_store_unit.sv
// ----------------------------------------------------------------------------
// ordered_unique_set_store_unit
// bounded set of distinct keys kept in insertion order
// ----------------------------------------------------------------------------
// Holds up to SET_CAPACITY distinct keys in arrival order in a single-port-read
// key memory, with a held-key count. One operation word in gives one result
// word out. Insert appends an absent key (refused with the full status when
// the set is full), remove deletes a held key and moves later keys down one
// place, query reports membership and read returns the key at a slot. Keys are
// compared on their low min(KEY_WIDTH, 32) bits; read values are sign-extended
// back to 32 bits. Items are handled one at a time: a read passes through the
// lookup and read-wait states; a lookup walks the stored keys from slot 0
// through the single comparator and the one read port of the key memory,
// stopping at a match; a remove then moves the later keys down one place
// each, one key at a time. The result sits in an output register, so the next
// word is taken while a result still waits; the sequencer only stalls when it
// has a new result and the output register is still full.
// ----------------------------------------------------------------------------
module ordered_unique_set_store_unit #(
  parameter int SET_CAPACITY = ouss_pkg::SET_CAPACITY_DEF,
  parameter int KEY_WIDTH    = ouss_pkg::KEY_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ouss_in_if.sink           in_ch,
  ouss_out_if.source        out_ch
);
  import ouss_pkg::*;

  // only the low SW key bits (at most 32) ever reach the store
  localparam int SW    = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
  localparam int IDX_W = $clog2(SET_CAPACITY);

  logic             accept;
  logic             in_rdy;
  logic             out_free;
  logic             done;
  res_t             res;
  res_t             res_r;
  logic             out_valid_r;

  // key memory port wiring
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [SW-1:0]    wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [SW-1:0]    rd_data;

  assign accept      = in_ch.valid && in_rdy;
  assign in_ch.ready = in_rdy;

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;

  ouss_seq #(
    .SET_CAPACITY (SET_CAPACITY),
    .SW           (SW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_operation (in_ch.operation),
    .in_key       (in_ch.key),
    .in_slot      (in_ch.slot),
    .in_rdy       (in_rdy),
    .out_free     (out_free),
    .done         (done),
    .res          (res),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  ouss_key_ram #(
    .DEPTH (SET_CAPACITY),
    .WIDTH (SW)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result word register, loaded only when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (done) begin
        res_r <= res;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = res_r.found;
  assign out_ch.read_value  = res_r.read_value;
  assign out_ch.entry_count = res_r.entry_count;
  assign out_ch.status      = res_r.status;

endmodule

>>> rtl/core/ouss_chk.sv
// ----------------------------------------------------------------------------
// ouss_chk
// port-level checks for the ordered unique set store, bound to the top level
// ----------------------------------------------------------------------------
`include "ordered_unique_set_store_unit_defines.svh"

module ouss_chk #(
  parameter int SET_CAPACITY = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [31:0] out_read_value,
  input logic [6:0]  out_entry_count,
  input logic [1:0]  out_status
);
  import ouss_pkg::*;

  localparam logic [6:0] CNT_LIMIT = 7'((SET_CAPACITY < 128) ? SET_CAPACITY : 127);

  // one word at a time: taking a word drops ready
  `OUSS_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
  `OUSS_ASSERT_IMP(a_count_bound, clk, rst_n, out_valid, out_entry_count <= CNT_LIMIT)
  `OUSS_ASSERT_IMP(a_full_not_found, clk, rst_n, out_valid && (out_status == ST_FULL), !out_found)
  `OUSS_ASSERT_IMP(a_range_zero, clk, rst_n, out_valid && (out_status == ST_RANGE), (out_read_value == 32'd0) && !out_found)
  `OUSS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_read_value) && $stable(out_entry_count))

endmodule

bind ordered_unique_set_store_unit ouss_chk #(
  .SET_CAPACITY (SET_CAPACITY)
) u_ouss_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_found       (out_ch.found),
  .out_read_value  (out_ch.read_value),
  .out_entry_count (out_ch.entry_count),
  .out_status      (out_ch.status)
);
